// ===== hdl/ltm_pkg.sv =====
// ----------------------------------------------------------------------------
// ltm_pkg
// Shared types and constants for the lock table manager: request and
// response payloads, status codes, table entry layout and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ltm_pkg;

   // Default number of table entries.
   localparam int unsigned LTM_LOCK_ENTRIES = 16;

   // Width of a lock identifier and of the acquire counter.
   localparam int unsigned LTM_ID_W    = 64;
   localparam int unsigned LTM_COUNT_W = 32;

   // Operation codes carried in a request.
   localparam logic LTM_OP_ACQUIRE = 1'b0;
   localparam logic LTM_OP_RELEASE = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BUSY     = 2'd1,
      ST_NOT_HELD = 2'd2,
      ST_FULL     = 2'd3
   } ltm_status_type;

   // Request payload.
   typedef struct packed {
      logic                operation;
      logic [LTM_ID_W-1:0] lock_id;
   } ltm_req_type;

   // Response payload.
   typedef struct packed {
      ltm_status_type         status;
      logic [LTM_COUNT_W-1:0] acquire_count;
   } ltm_rsp_type;

   // One word of the lock table memory.
   typedef struct packed {
      logic                locked;
      logic [LTM_ID_W-1:0] id;
   } ltm_entry_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } ltm_state_type;

endpackage : ltm_pkg

`default_nettype wire

// ===== hdl/lock_table_manager.sv =====
// ----------------------------------------------------------------------------
// lock_table_manager
// Lock table keyed by a 64-bit lock id, held in one synchronous memory.
// Each request acquires or releases a lock and returns one response with
// its status and the running count of successful acquires.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake               Payload
//   req_      in          req_valid / req_ready   ltm_req_type (operation, lock_id)
//   rsp_      out         rsp_valid / rsp_ready   ltm_rsp_type (status, acquire_count)
//
// After acceptance a request reads table words from index zero until its
// id matches or the fill count is reached, so it reads the matching index
// plus one words, or the fill count on a miss, through the single read port
// of the table memory, one word per cycle. The response is then registered;
// the next request is taken only once the block is back in idle.
// Entries are allocated from index zero upward and never freed, so a fill
// count stands in for per-entry valid bits; reset clears it at once.
// A response waiting on rsp_ready does not stop the next request from being
// accepted; only the final update waits for the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lock_table_manager #(
   parameter int unsigned LOCK_ENTRIES = ltm_pkg::LTM_LOCK_ENTRIES
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  ltm_pkg::ltm_req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output ltm_pkg::ltm_rsp_type rsp_payload
);

   import ltm_pkg::*;

   localparam int unsigned IDX_W  = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
   localparam int unsigned FILL_W = $clog2(LOCK_ENTRIES + 1);

   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LOCK_ENTRIES);

   // Table memory and its registered read data.
   ltm_entry_type mem [LOCK_ENTRIES];
   ltm_entry_type rd_data_ff;

   // Control state.
   ltm_state_type          state_ff, state_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [LTM_COUNT_W-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Request context and lookup result.
   logic                   op_ff, op_in;
   logic [LTM_ID_W-1:0]    id_ff, id_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic                   hit_ff, hit_in;
   logic                   locked_ff, locked_in;
   ltm_rsp_type            rsp_ff, rsp_in;

   // Memory port controls.
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   ltm_entry_type          wr_data;

   logic                   req_accept;
   logic                   rsp_free;
   logic [FILL_W-1:0]      ptr_plus;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign ptr_plus    = FILL_W'(ptr_ff) + FILL_W'(1);

   // Next state, lookup and table update.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      ptr_in       = ptr_ff;
      hit_in       = hit_ff;
      locked_in    = locked_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      rd_addr      = ptr_plus[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = '{locked: 1'b1, id: id_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in   = req_payload.operation;
               id_in   = req_payload.lock_id;
               ptr_in  = '0;
               hit_in  = 1'b0;
               rd_addr = '0;
               if (fill_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  rd_en    = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // Compare the word read last cycle; fetch the next one on a miss.
            if (rd_data_ff.id == id_ff) begin
               hit_in    = 1'b1;
               locked_in = rd_data_ff.locked;
               state_in  = S_DECIDE;
            end else if (ptr_plus == fill_ff) begin
               hit_in   = 1'b0;
               state_in = S_DECIDE;
            end else begin
               rd_en  = 1'b1;
               ptr_in = ptr_plus[IDX_W-1:0];
            end
         end

         S_DECIDE: begin
            // Apply the outcome once the response register can take it.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (op_ff == LTM_OP_ACQUIRE) begin
                  if (hit_ff) begin
                     if (locked_ff) begin
                        rsp_in.status = ST_BUSY;
                     end else begin
                        wr_en         = 1'b1;
                        count_in      = count_ff + LTM_COUNT_W'(1);
                        rsp_in.status = ST_OK;
                     end
                  end else if (fill_ff == FILL_MAX) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = fill_ff[IDX_W-1:0];
                     fill_in       = fill_ff + FILL_W'(1);
                     count_in      = count_ff + LTM_COUNT_W'(1);
                     rsp_in.status = ST_OK;
                  end
               end else begin
                  if (hit_ff && locked_ff) begin
                     wr_en         = 1'b1;
                     wr_data       = '{locked: 1'b0, id: id_ff};
                     rsp_in.status = ST_OK;
                  end else begin
                     rsp_in.status = ST_NOT_HELD;
                  end
               end
               rsp_in.acquire_count = count_in;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      id_ff     <= id_in;
      ptr_ff    <= ptr_in;
      hit_ff    <= hit_in;
      locked_ff <= locked_in;
      rsp_ff    <= rsp_in;
   end

   // Lock table memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= FILL_MAX)
      else $error("lock table fill count exceeds table size");

   // The scan only reads entries that have been allocated.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (FILL_W'(ptr_ff) < fill_ff))
      else $error("lock table scan beyond fill count");

   // A full status is only reported when every entry is allocated.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_FULL)) |-> (fill_ff == FILL_MAX))
      else $error("full status with free entries left");

   // A successful acquire bumps the counter by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DECIDE) && rsp_free && (op_ff == LTM_OP_ACQUIRE) &&
       (rsp_in.status == ST_OK))
      |=> (count_ff == $past(count_ff) + LTM_COUNT_W'(1)))
      else $error("acquire counter did not advance on a granted lock");

endmodule : lock_table_manager

`default_nettype wire

// ===== tb/ltm_tracker_pkg.sv =====
// ----------------------------------------------------------------------------
// ltm_tracker_pkg
// Lock table tracker for the lock table manager testbench. It mirrors the
// table contents and the acquire counter, works out the response that each
// accepted request must produce, and compares arriving responses with them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ltm_tracker_pkg;

   import ltm_pkg::*;

   class lock_table_tracker;

      // Mirror of the lock table and the acquire counter.
      logic [LTM_ID_W-1:0]    slot_id   [LTM_LOCK_ENTRIES];
      bit                     slot_used [LTM_LOCK_ENTRIES];
      bit                     slot_held [LTM_LOCK_ENTRIES];
      logic [LTM_COUNT_W-1:0] acquires;

      // Responses still owed by the block, oldest first.
      ltm_rsp_type            expected_replies [$];
      int unsigned            mismatches;

      function new();
         foreach (slot_used[i]) begin
            slot_id[i]   = '0;
            slot_used[i] = 1'b0;
            slot_held[i] = 1'b0;
         end
         acquires   = '0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return expected_replies.size();
      endfunction

      // Apply one accepted request to the mirror and queue its response.
      function void note_request(ltm_req_type req);
         int          hit;
         int          free_slot;
         ltm_rsp_type reply;
         hit       = -1;
         free_slot = -1;
         // Scan downward so that the lowest matching and lowest free index win.
         for (int i = LTM_LOCK_ENTRIES - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_id[i] == req.lock_id) begin
               hit = i;
            end
            if (!slot_used[i]) begin
               free_slot = i;
            end
         end
         if (req.operation == LTM_OP_ACQUIRE) begin
            if (hit >= 0) begin
               if (slot_held[hit]) begin
                  reply.status = ST_BUSY;
               end else begin
                  slot_held[hit] = 1'b1;
                  acquires       = acquires + 1'b1;
                  reply.status   = ST_OK;
               end
            end else if (free_slot < 0) begin
               reply.status = ST_FULL;
            end else begin
               slot_id[free_slot]   = req.lock_id;
               slot_used[free_slot] = 1'b1;
               slot_held[free_slot] = 1'b1;
               acquires             = acquires + 1'b1;
               reply.status         = ST_OK;
            end
         end else begin
            if (hit >= 0 && slot_held[hit]) begin
               slot_held[hit] = 1'b0;
               reply.status   = ST_OK;
            end else begin
               reply.status = ST_NOT_HELD;
            end
         end
         reply.acquire_count = acquires;
         expected_replies.push_back(reply);
      endfunction

      // Print one line for a mismatch and count it.
      task report_mismatch(string msg);
         $display("MISMATCH at %0t ns: %s", $time, msg);
         mismatches++;
      endtask

      // Compare one response with the oldest outstanding expectation.
      task check_response(ltm_rsp_type got);
         ltm_rsp_type want;
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("response status %0d count %0d with no request outstanding",
                                      got.status, got.acquire_count));
            return;
         end
         want = expected_replies.pop_front();
         if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         end
         if (got.acquire_count !== want.acquire_count) begin
            report_mismatch($sformatf("acquire_count %0d, expected %0d",
                                      got.acquire_count, want.acquire_count));
         end
      endtask

   endclass

endpackage : ltm_tracker_pkg

// ===== tb/tb_lock_table_manager.sv =====
// ----------------------------------------------------------------------------
// tb_lock_table_manager
// Testbench for the lock table manager. A short directed sequence walks the
// acquire and release outcomes on extreme and neighboring ids, then random
// requests drawn mostly from a small id pool fill the table and keep hitting
// it. Both channels stall in random bursts; responses are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lock_table_manager;

   import ltm_pkg::*;
   import ltm_tracker_pkg::*;

   localparam int unsigned RANDOM_REQUESTS = 1800;
   localparam int unsigned QUIET_FROM      = 1600;
   localparam int unsigned POOL_SIZE       = 24;
   localparam int unsigned SETTLE_CYCLES   = 40;
   localparam int unsigned CYCLE_LIMIT     = 500000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   ltm_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   ltm_rsp_type rsp_payload;

   lock_table_tracker   tracker;
   logic [LTM_ID_W-1:0] id_pool [POOL_SIZE];
   bit                  quiet_tail;
   int unsigned         cycle_count;

   lock_table_manager u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Clock generation, 20 ns period.
   initial begin
      clock = 1'b0;
   end
   always #10 clock = ~clock;

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
   end
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Response side: ready drops in random bursts until the quiet tail.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   // Every response handshake is checked against the tracker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_response(rsp_payload);
      end
   end

   // Drive one request, with an occasional idle burst before it, and record
   // it in the tracker once the block has taken it.
   task automatic send_request(input logic op, input logic [LTM_ID_W-1:0] id);
      ltm_req_type item;
      item.operation = op;
      item.lock_id   = id;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(item);
      @(negedge clock);
   endtask

   // Random request: mostly pool ids so that entries are hit again, with
   // some fresh ids that allocate early on and meet a full table later.
   task automatic send_random_request();
      logic                op;
      logic [LTM_ID_W-1:0] id;
      op = ($urandom_range(0, 99) < 55) ? LTM_OP_ACQUIRE : LTM_OP_RELEASE;
      if ($urandom_range(0, 99) < 85) begin
         id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         id = {$urandom(), $urandom()};
      end
      send_request(op, id);
   endtask

   // Main sequence.
   initial begin
      logic [LTM_ID_W-1:0] ones;
      logic [LTM_ID_W-1:0] top_bit;
      ones    = '1;
      top_bit = {1'b1, {(LTM_ID_W - 1){1'b0}}};
      tracker     = new();
      quiet_tail  = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;

      // Id pool: extremes, single-bit neighbors and random values.
      id_pool[0] = '0;
      id_pool[1] = ones;
      id_pool[2] = 64'd1;
      id_pool[3] = top_bit;
      for (int i = 4; i < POOL_SIZE; i += 2) begin
         id_pool[i]     = {$urandom(), $urandom()};
         id_pool[i + 1] = id_pool[i] ^ (64'd1 << $urandom_range(0, LTM_ID_W - 1));
      end

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: release on an empty table, busy, free known id, re-acquire
      // of an existing entry, and ids that differ from held ones in one bit.
      send_request(LTM_OP_RELEASE, '0);
      send_request(LTM_OP_ACQUIRE, '0);
      send_request(LTM_OP_ACQUIRE, '0);
      send_request(LTM_OP_RELEASE, '0);
      send_request(LTM_OP_RELEASE, '0);
      send_request(LTM_OP_ACQUIRE, '0);
      send_request(LTM_OP_ACQUIRE, ones);
      send_request(LTM_OP_ACQUIRE, 64'd1);
      send_request(LTM_OP_ACQUIRE, top_bit);
      send_request(LTM_OP_RELEASE, ones);
      send_request(LTM_OP_RELEASE, ~top_bit);
      send_request(LTM_OP_ACQUIRE, ones);
      send_request(LTM_OP_ACQUIRE, ones);
      send_request(LTM_OP_RELEASE, 64'd1);
      send_request(LTM_OP_RELEASE, top_bit);
      send_request(LTM_OP_RELEASE, '0);
      send_request(LTM_OP_RELEASE, 64'd2);
      send_request(LTM_OP_ACQUIRE, 64'd1);

      // Random part; the last stretch runs with no idling on either side.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         quiet_tail = (n >= QUIET_FROM);
         send_random_request();
      end
      req_valid <= 1'b0;

      // Drain, then watch a little longer for stray responses.
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule : tb_lock_table_manager

// ===== filelist.f =====
hdl/ltm_pkg.sv
hdl/lock_table_manager.sv
tb/ltm_tracker_pkg.sv
tb/tb_lock_table_manager.sv
